// ----- hdl/thick_line_rasterizer_unit_assert.svh -----
// -----------------------------------------------------------------------------
// Thick line rasterizer assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// -----------------------------------------------------------------------------
`ifndef THICK_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define THICK_LINE_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define TLR_CHECK(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("thick line rasterizer check failed");

// next-cycle implication
`define TLR_CHECK_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("thick line rasterizer check failed");

`endif

// ----- hdl/tlr_pkg.sv -----
// -----------------------------------------------------------------------------
// Thick line rasterizer package
// Screen size, field widths, command and rectangle types.
// -----------------------------------------------------------------------------
package tlr_pkg;

    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 128;

    localparam int COORD_W = 12;
    localparam int POS_W   = 14;
    localparam int SIZE_W  = 15;
    localparam int CLIP_W  = 16;
    localparam int DELTA_W = 13;
    localparam int ERR_W   = 16;
    localparam int BRUSH_W = 8;
    localparam int COLOR_W = 16;

    localparam int RECT_X_W = 8;
    localparam int RECT_Y_W = 7;
    localparam int RECT_W_W = 8;
    localparam int RECT_H_W = 8;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_AXIS,
        CMD_WALK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic signed [POS_W-1:0]     org_x;
        logic signed [POS_W-1:0]     org_y;
        logic signed [COORD_W-1:0]   end_x;
        logic signed [COORD_W-1:0]   end_y;
        logic signed [SIZE_W-1:0]    size_w;
        logic signed [SIZE_W-1:0]    size_h;
        logic signed [DELTA_W-1:0]   delta_x;
        logic signed [DELTA_W-1:0]   delta_y_neg;
        logic                        step_x_neg;
        logic                        step_y_neg;
        logic [BRUSH_W-1:0]          brush;
        logic [COLOR_W-1:0]          color;
    } cmd_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [SIZE_W-1:0] w;
        logic signed [SIZE_W-1:0] h;
        logic [COLOR_W-1:0]       color;
        logic                     last;
    } rect_t;

    typedef struct packed {
        logic [RECT_X_W-1:0] x;
        logic [RECT_Y_W-1:0] y;
        logic [RECT_W_W-1:0] w;
        logic [RECT_H_W-1:0] h;
        logic [COLOR_W-1:0]  color;
        logic                visible;
        logic                last;
    } out_rect_t;

endpackage

// ----- hdl/thick_line_rasterizer_unit.sv -----
// -----------------------------------------------------------------------------
// Thick line rasterizer
// Bresenham line walk with a square brush, one clipped rectangle per busy tick.
//
// channel  dir  tdata                                        tuser     tlast
// s_axis   in   x_start, y_start, x_end, y_end, thickness,   func      -
//               line_color
// m_axis   out  rect_x, rect_y, rect_w, rect_h, fill_color   visible   last
//
// One input transfer per cycle while the queue has room; one rect per busy tick.
// At the earliest, a tick's rectangle is written to the queue on its transfer
// edge, then passes the step register and the clip register before it is valid.
// Loads and ticks while idle produce no output transfer.
// Reset clears the queue and both stage valids; no clearing pass.
// An output stall fills the four-entry queue, then drops s_axis_tready.
// -----------------------------------------------------------------------------
module thick_line_rasterizer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // x_start, y_start, x_end, y_end, thickness, line_color
    input  logic [tlr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // rect_x, rect_y, rect_w, rect_h, fill_color, zero pad
    output logic [tlr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // visible
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);
    import tlr_pkg::*;

`include "thick_line_rasterizer_unit_assert.svh"

    logic      push, pop, full, empty;
    cmd_t      push_cmd, head_cmd;
    logic      rect_valid, rect_ready;
    rect_t     rect;
    out_rect_t out_rect;
    logic      vis_out, hid_out, x_fits, y_fits;

    tlr_front u_front (
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_func  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .push     (push),
        .cmd      (push_cmd),
        .full     (full)
    );

    tlr_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_cmd),
        .full    (full),
        .pop     (pop),
        .rd_data (head_cmd),
        .empty   (empty)
    );

    tlr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (head_cmd),
        .empty      (empty),
        .pop        (pop),
        .rect_valid (rect_valid),
        .rect_ready (rect_ready),
        .rect       (rect)
    );

    tlr_clip u_clip (
        .clk        (clk),
        .rst_n      (rst_n),
        .rect_valid (rect_valid),
        .rect_ready (rect_ready),
        .rect       (rect),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_rect   (out_rect)
    );

    assign m_axis_tdata = {1'b0, out_rect.color, out_rect.h, out_rect.w,
                           out_rect.y, out_rect.x};
    assign m_axis_tuser = out_rect.visible;
    assign m_axis_tlast = out_rect.last;

    assign vis_out = m_axis_tvalid && m_axis_tuser;
    assign hid_out = m_axis_tvalid && !m_axis_tuser;
    assign x_fits  = (12'(out_rect.x) + 12'(out_rect.w) <= 12'(SCREEN_WIDTH))
                   && (out_rect.w != '0);
    assign y_fits  = (12'(out_rect.y) + 12'(out_rect.h) <= 12'(SCREEN_HEIGHT))
                   && (out_rect.h != '0);

    `TLR_CHECK(a_vis_in_width, vis_out, x_fits)
    `TLR_CHECK(a_vis_in_height, vis_out, y_fits)
    `TLR_CHECK(a_hidden_zero, hid_out, m_axis_tdata[30:0] == '0)
    `TLR_CHECK_NEXT(a_rect_hold, rect_valid && !rect_ready, rect_valid && $stable(rect))

endmodule

// ----- hdl/tlr_fifo.sv -----
// -----------------------------------------------------------------------------
// Command queue
// Small register queue between the classifier and the line stepper.
// -----------------------------------------------------------------------------
module tlr_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tlr_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          pop,
    output tlr_pkg::cmd_t rd_data,
    output logic          empty
);
    import tlr_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/tlr_front.sv -----
// -----------------------------------------------------------------------------
// Input classifier
// Unpacks an input transfer and turns it into a tick, axis or walk command.
// -----------------------------------------------------------------------------
module tlr_front (
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_func,
    input  logic [tlr_pkg::S_TDATA_W-1:0]  in_data,
    output logic                           push,
    output tlr_pkg::cmd_t                  cmd,
    input  logic                           full
);
    import tlr_pkg::*;

    logic signed [COORD_W-1:0] x0, y0, x1, y1;
    logic [BRUSH_W-1:0]        brush;
    logic [COLOR_W-1:0]        color;
    logic signed [POS_W-1:0]   half;
    logic signed [DELTA_W-1:0] diff_x, diff_y, abs_x, abs_y;
    logic signed [COORD_W-1:0] min_x, min_y;

    assign x0    = in_data[11:0];
    assign y0    = in_data[23:12];
    assign x1    = in_data[35:24];
    assign y1    = in_data[47:36];
    assign brush = in_data[55:48];
    assign color = in_data[71:56];

    assign in_ready = !full;
    assign push     = in_valid && !full;

    assign half   = POS_W'(brush >> 1);
    assign diff_x = DELTA_W'(x1) - DELTA_W'(x0);
    assign diff_y = DELTA_W'(y1) - DELTA_W'(y0);
    assign abs_x  = diff_x[DELTA_W-1] ? -diff_x : diff_x;
    assign abs_y  = diff_y[DELTA_W-1] ? -diff_y : diff_y;
    assign min_x  = (x0 < x1) ? x0 : x1;
    assign min_y  = (y0 < y1) ? y0 : y1;

    always_comb
    begin
        cmd       = '0;
        cmd.kind  = CMD_TICK;
        cmd.brush = brush;
        cmd.color = color;
        if (in_func == FUNC_LOAD)
        begin
            if (x0 == x1)
            begin
                cmd.kind   = CMD_AXIS;
                cmd.org_x  = POS_W'(x0) - half;
                cmd.org_y  = POS_W'(min_y) - half;
                cmd.size_w = SIZE_W'(brush);
                cmd.size_h = SIZE_W'(abs_y) + SIZE_W'(brush);
            end
            else if (y0 == y1)
            begin
                cmd.kind   = CMD_AXIS;
                cmd.org_x  = POS_W'(min_x) - half;
                cmd.org_y  = POS_W'(y0) - half;
                cmd.size_w = SIZE_W'(abs_x) + SIZE_W'(brush);
                cmd.size_h = SIZE_W'(brush);
            end
            else
            begin
                cmd.kind        = CMD_WALK;
                cmd.org_x       = POS_W'(x0);
                cmd.org_y       = POS_W'(y0);
                cmd.end_x       = x1;
                cmd.end_y       = y1;
                cmd.delta_x     = abs_x;
                cmd.delta_y_neg = -abs_y;
                cmd.step_x_neg  = !(x0 < x1);
                cmd.step_y_neg  = !(y0 < y1);
            end
        end
    end

endmodule

// ----- hdl/tlr_back.sv -----
// -----------------------------------------------------------------------------
// Line stepper
// Holds the current line and emits one raw rectangle per busy tick.
// -----------------------------------------------------------------------------
module tlr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  tlr_pkg::cmd_t cmd,
    input  logic          empty,
    output logic          pop,
    output logic          rect_valid,
    input  logic          rect_ready,
    output tlr_pkg::rect_t rect
);
    import tlr_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_AXIS,
        MODE_WALK
    } mode_t;

    mode_t                     mode_reg, mode_next;
    logic signed [COORD_W-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [COORD_W-1:0] end_x_reg, end_x_next, end_y_reg, end_y_next;
    logic signed [DELTA_W-1:0] dx_reg, dx_next, dyn_reg, dyn_next;
    logic                      sxn_reg, sxn_next, syn_reg, syn_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [BRUSH_W-1:0]        brush_reg, brush_next;
    logic [COLOR_W-1:0]        color_reg, color_next;
    logic signed [POS_W-1:0]   ax_x_reg, ax_x_next, ax_y_reg, ax_y_next;
    logic signed [SIZE_W-1:0]  ax_w_reg, ax_w_next, ax_h_reg, ax_h_next;
    logic                      rect_valid_reg, rect_valid_next;
    rect_t                     rect_reg, rect_next;

    logic                      advance;
    logic                      done;
    logic signed [ERR_W:0]     e2;
    logic                      step_x, step_y;
    logic signed [POS_W-1:0]   half;
    rect_t                     walk_rect;

    assign advance    = !empty && (!rect_valid_reg || rect_ready);
    assign pop        = advance;
    assign rect_valid = rect_valid_reg;
    assign rect       = rect_reg;

    assign done   = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
    assign e2     = {err_reg, 1'b0};
    assign step_x = (e2 >= (ERR_W+1)'(dyn_reg));
    assign step_y = (e2 <= (ERR_W+1)'(dx_reg));
    assign half   = POS_W'(brush_reg >> 1);

    always_comb
    begin
        walk_rect.color = color_reg;
        walk_rect.last  = done;
        if (brush_reg <= BRUSH_W'(1))
        begin
            walk_rect.x = POS_W'(cur_x_reg);
            walk_rect.y = POS_W'(cur_y_reg);
            walk_rect.w = SIZE_W'(1);
            walk_rect.h = SIZE_W'(1);
        end
        else
        begin
            walk_rect.x = POS_W'(cur_x_reg) - half;
            walk_rect.y = POS_W'(cur_y_reg) - half;
            walk_rect.w = SIZE_W'(brush_reg);
            walk_rect.h = SIZE_W'(brush_reg);
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        end_x_next      = end_x_reg;
        end_y_next      = end_y_reg;
        dx_next         = dx_reg;
        dyn_next        = dyn_reg;
        sxn_next        = sxn_reg;
        syn_next        = syn_reg;
        err_next        = err_reg;
        brush_next      = brush_reg;
        color_next      = color_reg;
        ax_x_next       = ax_x_reg;
        ax_y_next       = ax_y_reg;
        ax_w_next       = ax_w_reg;
        ax_h_next       = ax_h_reg;
        rect_valid_next = rect_valid_reg && !rect_ready;
        rect_next       = rect_reg;
        if (advance)
        begin
            case (cmd.kind)
                CMD_AXIS:
                begin
                    mode_next  = MODE_AXIS;
                    ax_x_next  = cmd.org_x;
                    ax_y_next  = cmd.org_y;
                    ax_w_next  = cmd.size_w;
                    ax_h_next  = cmd.size_h;
                    brush_next = cmd.brush;
                    color_next = cmd.color;
                end
                CMD_WALK:
                begin
                    mode_next  = MODE_WALK;
                    cur_x_next = cmd.org_x[COORD_W-1:0];
                    cur_y_next = cmd.org_y[COORD_W-1:0];
                    end_x_next = cmd.end_x;
                    end_y_next = cmd.end_y;
                    dx_next    = cmd.delta_x;
                    dyn_next   = cmd.delta_y_neg;
                    sxn_next   = cmd.step_x_neg;
                    syn_next   = cmd.step_y_neg;
                    err_next   = ERR_W'(cmd.delta_x) + ERR_W'(cmd.delta_y_neg);
                    brush_next = cmd.brush;
                    color_next = cmd.color;
                end
                CMD_TICK:
                begin
                    case (mode_reg)
                        MODE_AXIS:
                        begin
                            rect_valid_next = 1'b1;
                            rect_next.x     = ax_x_reg;
                            rect_next.y     = ax_y_reg;
                            rect_next.w     = ax_w_reg;
                            rect_next.h     = ax_h_reg;
                            rect_next.color = color_reg;
                            rect_next.last  = 1'b1;
                            mode_next       = MODE_IDLE;
                        end
                        MODE_WALK:
                        begin
                            rect_valid_next = 1'b1;
                            rect_next       = walk_rect;
                            if (done)
                            begin
                                mode_next = MODE_IDLE;
                            end
                            else
                            begin
                                err_next = err_reg
                                         + (step_x ? ERR_W'(dyn_reg) : '0)
                                         + (step_y ? ERR_W'(dx_reg) : '0);
                                if (step_x)
                                begin
                                    cur_x_next = sxn_reg ? cur_x_reg - 1'b1
                                                         : cur_x_reg + 1'b1;
                                end
                                if (step_y)
                                begin
                                    cur_y_next = syn_reg ? cur_y_reg - 1'b1
                                                         : cur_y_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            end_x_reg      <= '0;
            end_y_reg      <= '0;
            dx_reg         <= '0;
            dyn_reg        <= '0;
            sxn_reg        <= 1'b0;
            syn_reg        <= 1'b0;
            err_reg        <= '0;
            brush_reg      <= '0;
            color_reg      <= '0;
            ax_x_reg       <= '0;
            ax_y_reg       <= '0;
            ax_w_reg       <= '0;
            ax_h_reg       <= '0;
            rect_valid_reg <= 1'b0;
            rect_reg       <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            end_x_reg      <= end_x_next;
            end_y_reg      <= end_y_next;
            dx_reg         <= dx_next;
            dyn_reg        <= dyn_next;
            sxn_reg        <= sxn_next;
            syn_reg        <= syn_next;
            err_reg        <= err_next;
            brush_reg      <= brush_next;
            color_reg      <= color_next;
            ax_x_reg       <= ax_x_next;
            ax_y_reg       <= ax_y_next;
            ax_w_reg       <= ax_w_next;
            ax_h_reg       <= ax_h_next;
            rect_valid_reg <= rect_valid_next;
            rect_reg       <= rect_next;
        end
    end

endmodule

// ----- hdl/tlr_clip.sv -----
// -----------------------------------------------------------------------------
// Screen clipper
// Clips a raw rectangle to the screen and holds it in the output register.
// -----------------------------------------------------------------------------
module tlr_clip (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rect_valid,
    output logic               rect_ready,
    input  tlr_pkg::rect_t     rect,
    output logic               out_valid,
    input  logic               out_ready,
    output tlr_pkg::out_rect_t out_rect
);
    import tlr_pkg::*;

    localparam logic signed [CLIP_W-1:0] SCR_W = CLIP_W'(SCREEN_WIDTH);
    localparam logic signed [CLIP_W-1:0] SCR_H = CLIP_W'(SCREEN_HEIGHT);

    logic signed [CLIP_W-1:0] x0, y0, w0, h0;
    logic signed [CLIP_W-1:0] x1, y1, w1, h1, w2, h2;
    logic                     vis;
    logic                     take;

    logic      out_valid_reg, out_valid_next;
    out_rect_t out_reg, out_next;

    assign x0 = CLIP_W'(rect.x);
    assign y0 = CLIP_W'(rect.y);
    assign w0 = CLIP_W'(rect.w);
    assign h0 = CLIP_W'(rect.h);

    assign x1 = x0[CLIP_W-1] ? '0 : x0;
    assign w1 = x0[CLIP_W-1] ? w0 + x0 : w0;
    assign y1 = y0[CLIP_W-1] ? '0 : y0;
    assign h1 = y0[CLIP_W-1] ? h0 + y0 : h0;
    assign w2 = (x1 + w1 > SCR_W) ? SCR_W - x1 : w1;
    assign h2 = (y1 + h1 > SCR_H) ? SCR_H - y1 : h1;
    assign vis = !(w2 <= 0 || h2 <= 0 || x1 >= SCR_W || y1 >= SCR_H);

    assign rect_ready = !out_valid_reg || out_ready;
    assign take       = rect_valid && rect_ready;
    assign out_valid  = out_valid_reg;
    assign out_rect   = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (take)
        begin
            out_valid_next   = 1'b1;
            out_next.x       = vis ? x1[RECT_X_W-1:0] : '0;
            out_next.y       = vis ? y1[RECT_Y_W-1:0] : '0;
            out_next.w       = vis ? w2[RECT_W_W-1:0] : '0;
            out_next.h       = vis ? h2[RECT_H_W-1:0] : '0;
            out_next.color   = rect.color;
            out_next.visible = vis;
            out_next.last    = rect.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

// ----- tb/tb_thick_line_rasterizer_unit.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Thick line rasterizer testbench
// Loads lines and clocks ticks through the stream input, while the output
// side is stalled at random. Each output transfer is compared with a local
// line-walk and clip model. Directed lines come first: axis lines, single
// points, the coordinate extremes, brush sizes from 0 to 255, and lines
// replaced in mid-walk. Random short lines and full-range noise follow.
// -----------------------------------------------------------------------------

typedef enum int {
    LINE_IDLE,
    LINE_AXIS,
    LINE_WALK
} line_mode_t;

class rect_scoreboard;

    tlr_pkg::out_rect_t pending_rects[$];
    line_mode_t         mode = LINE_IDLE;

    logic signed [12:0] cur_x = '0;
    logic signed [12:0] cur_y = '0;
    logic signed [11:0] end_x = '0;
    logic signed [11:0] end_y = '0;
    logic signed [12:0] delta_x = '0;
    logic signed [12:0] delta_y_neg = '0;
    bit                 step_x_neg = 1'b0;
    bit                 step_y_neg = 1'b0;
    logic signed [15:0] error_term = '0;
    logic [7:0]         brush = '0;
    logic [15:0]        held_color = '0;
    logic signed [13:0] axis_x = '0;
    logic signed [13:0] axis_y = '0;
    logic signed [14:0] axis_w = '0;
    logic signed [14:0] axis_h = '0;

    int loads;
    int line_ticks;
    int idle_ticks;
    int rects_seen;
    int rects_visible;
    int failures;

    function void flag_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    function tlr_pkg::out_rect_t clip_rect(int x, int y, int w, int h, bit last);
        tlr_pkg::out_rect_t r;
        bit                 vis;
        if (x < 0) begin
            w = w + x;
            x = 0;
        end
        if (y < 0) begin
            h = h + y;
            y = 0;
        end
        if (x + w > tlr_pkg::SCREEN_WIDTH) w = tlr_pkg::SCREEN_WIDTH - x;
        if (y + h > tlr_pkg::SCREEN_HEIGHT) h = tlr_pkg::SCREEN_HEIGHT - y;
        vis = !(w <= 0 || h <= 0 || x >= tlr_pkg::SCREEN_WIDTH ||
                y >= tlr_pkg::SCREEN_HEIGHT);
        if (!vis) begin
            x = 0;
            y = 0;
            w = 0;
            h = 0;
        end
        r.x       = x[7:0];
        r.y       = y[6:0];
        r.w       = w[7:0];
        r.h       = h[7:0];
        r.color   = held_color;
        r.visible = vis;
        r.last    = last;
        return r;
    endfunction

    function void note_transfer(logic func, logic [71:0] data);
        int x0;
        int y0;
        int x1;
        int y1;
        int half;
        int e2;
        bit at_end;
        if (func == tlr_pkg::FUNC_LOAD) begin
            loads++;
            x0 = int'($signed(data[11:0]));
            y0 = int'($signed(data[23:12]));
            x1 = int'($signed(data[35:24]));
            y1 = int'($signed(data[47:36]));
            brush      = data[55:48];
            held_color = data[71:56];
            half = int'(brush) / 2;
            if (x0 == x1) begin
                mode   = LINE_AXIS;
                axis_x = 14'(x0 - half);
                axis_y = 14'(((y0 < y1) ? y0 : y1) - half);
                axis_w = 15'(brush);
                axis_h = 15'(((y1 > y0) ? y1 - y0 : y0 - y1) + int'(brush));
            end
            else if (y0 == y1) begin
                mode   = LINE_AXIS;
                axis_x = 14'(((x0 < x1) ? x0 : x1) - half);
                axis_y = 14'(y0 - half);
                axis_w = 15'(((x1 > x0) ? x1 - x0 : x0 - x1) + int'(brush));
                axis_h = 15'(brush);
            end
            else begin
                mode        = LINE_WALK;
                cur_x       = 13'(x0);
                cur_y       = 13'(y0);
                end_x       = 12'(x1);
                end_y       = 12'(y1);
                delta_x     = 13'((x1 > x0) ? x1 - x0 : x0 - x1);
                delta_y_neg = 13'(-((y1 > y0) ? y1 - y0 : y0 - y1));
                step_x_neg  = !(x0 < x1);
                step_y_neg  = !(y0 < y1);
                error_term  = 16'(int'(delta_x) + int'(delta_y_neg));
            end
        end
        else if (mode == LINE_AXIS) begin
            line_ticks++;
            pending_rects.push_back(clip_rect(int'(axis_x), int'(axis_y),
                                              int'(axis_w), int'(axis_h), 1'b1));
            mode = LINE_IDLE;
        end
        else if (mode == LINE_WALK) begin
            line_ticks++;
            at_end = (int'(cur_x) == int'(end_x)) && (int'(cur_y) == int'(end_y));
            half   = int'(brush) / 2;
            if (brush <= 8'd1)
                pending_rects.push_back(clip_rect(int'(cur_x), int'(cur_y), 1, 1, at_end));
            else
                pending_rects.push_back(clip_rect(int'(cur_x) - half, int'(cur_y) - half,
                                                  int'(brush), int'(brush), at_end));
            if (at_end) begin
                mode = LINE_IDLE;
            end
            else begin
                e2 = 2 * int'(error_term);
                if (e2 >= int'(delta_y_neg)) begin
                    error_term = 16'(int'(error_term) + int'(delta_y_neg));
                    cur_x      = 13'(int'(cur_x) + (step_x_neg ? -1 : 1));
                end
                if (e2 <= int'(delta_x)) begin
                    error_term = 16'(int'(error_term) + int'(delta_x));
                    cur_y      = 13'(int'(cur_y) + (step_y_neg ? -1 : 1));
                end
            end
        end
        else begin
            idle_ticks++;
        end
    endfunction

    function void check_rect(tlr_pkg::out_rect_t got);
        tlr_pkg::out_rect_t want;
        rects_seen++;
        if (got.visible) rects_visible++;
        if (pending_rects.size() == 0) begin
            flag_failure($sformatf("unexpected rect x=%0d y=%0d w=%0d h=%0d c=%h v=%0d l=%0d",
                                   got.x, got.y, got.w, got.h, got.color,
                                   got.visible, got.last));
            return;
        end
        want = pending_rects.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
            got.h !== want.h || got.color !== want.color ||
            got.visible !== want.visible || got.last !== want.last)
            flag_failure($sformatf({"expected x=%0d y=%0d w=%0d h=%0d c=%h v=%0d l=%0d, ",
                                    "got x=%0d y=%0d w=%0d h=%0d c=%h v=%0d l=%0d"},
                                   want.x, want.y, want.w, want.h, want.color,
                                   want.visible, want.last,
                                   got.x, got.y, got.w, got.h, got.color,
                                   got.visible, got.last));
    endfunction

endclass

module tb_thick_line_rasterizer_unit;

    import tlr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 700;
    localparam int DRAIN_CYCLES  = 16;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    rect_scoreboard sb;
    int             send_idle_pct = 18;
    int             stall_pct = 70;
    int             cycles = 0;

    thick_line_rasterizer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin : rect_sink
        out_rect_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x       = m_tdata[7:0];
            got.y       = m_tdata[14:8];
            got.w       = m_tdata[22:15];
            got.h       = m_tdata[30:23];
            got.color   = m_tdata[46:31];
            got.visible = m_tuser;
            got.last    = m_tlast;
            sb.check_rect(got);
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_item(input logic func, input logic [S_TDATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_transfer(func, data);
    endtask

    task automatic load_line(input int x0, input int y0, input int x1, input int y1,
                             input int thick, input int color);
        logic [11:0] ax0;
        logic [11:0] ay0;
        logic [11:0] ax1;
        logic [11:0] ay1;
        logic [7:0]  th;
        logic [15:0] co;
        ax0 = x0[11:0];
        ay0 = y0[11:0];
        ax1 = x1[11:0];
        ay1 = y1[11:0];
        th  = thick[7:0];
        co  = color[15:0];
        send_item(FUNC_LOAD, {co, th, ay1, ax1, ay0, ax0});
    endtask

    task automatic tick_line(input int n);
        logic [S_TDATA_W-1:0] junk;
        for (int i = 0; i < n; i++)
        begin
            junk = S_TDATA_W'({$urandom, $urandom, $urandom});
            send_item(FUNC_TICK, junk);
        end
    endtask

    task automatic finish_line();
        while (sb.mode != LINE_IDLE) tick_line(1);
    endtask

    initial
    begin
        int base;
        int done_items;
        int pick;
        int x0;
        int y0;
        int x1;
        int y1;
        int thick;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines
        tick_line(1);
        load_line(10, 5, 10, 40, 3, 'hFFFF);
        tick_line(1);
        load_line(150, -3, -10, -3, 8, 'h07E0);
        tick_line(1);
        load_line(0, 0, 0, 0, 0, 'hF800);
        tick_line(1);
        load_line(-2048, 60, 2047, 60, 255, 'h001F);
        tick_line(1);
        load_line(2, 2, 6, 4, 1, 'h1234);
        finish_line();
        load_line(5, 5, 1, 2, 0, 'hABCD);
        finish_line();
        load_line(80, 64, 81, 65, 255, 'h5A5A);
        finish_line();
        load_line(2047, 2047, -2048, -2048, 2, 'h0000);
        tick_line(2);
        load_line(-2048, 2047, 2047, -2048, 128, 'hA5A5);
        tick_line(2);
        load_line(159, 127, 159, 200, 1, 'h8001);
        finish_line();
        tick_line(1);

        base = sb.loads + sb.line_ticks;
        done_items = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            if (done_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 18;
                stall_pct     = 70;
            end
            else if (done_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 70;
                stall_pct     = 18;
            end
            else
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end

            pick = $urandom_range(5);
            case (pick)
                0: thick = 0;
                1: thick = 1;
                2: thick = 2;
                3: thick = $urandom_range(3, 12);
                4: thick = $urandom_range(13, 40);
                default: thick = $urandom_range(255);
            endcase

            pick = $urandom_range(99);
            if (pick < 75)
            begin
                x0 = int'($urandom_range(219)) - 30;
                y0 = int'($urandom_range(187)) - 30;
                case ($urandom_range(3))
                    0:
                    begin
                        x1 = x0;
                        y1 = y0 + int'($urandom_range(80)) - 40;
                    end
                    1:
                    begin
                        y1 = y0;
                        x1 = x0 + int'($urandom_range(80)) - 40;
                    end
                    default:
                    begin
                        x1 = x0 + int'($urandom_range(40)) - 20;
                        y1 = y0 + int'($urandom_range(40)) - 20;
                    end
                endcase
                load_line(x0, y0, x1, y1, thick, $urandom);
                if (pick < 62)
                    finish_line();
                else
                    tick_line($urandom_range(3));
            end
            else if (pick < 88)
            begin
                x0 = $urandom;
                y0 = $urandom;
                x1 = $urandom;
                y1 = $urandom;
                case ($urandom_range(2))
                    0: x1 = x0;
                    1: y1 = y0;
                    default: ;
                endcase
                load_line(x0, y0, x1, y1, $urandom_range(255), $urandom);
                tick_line($urandom_range(4));
            end
            else
            begin
                // drain, then tick while idle
                finish_line();
                tick_line($urandom_range(1, 3));
            end
            done_items = sb.loads + sb.line_ticks - base;
        end
        finish_line();

        s_tvalid <= 1'b0;
        while (sb.pending_rects.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending_rects.size() != 0)
            sb.flag_failure($sformatf("%0d rects never arrived", sb.pending_rects.size()));

        $display("Run covered %0d line loads, %0d drawing ticks and %0d idle ticks;",
                 sb.loads, sb.line_ticks, sb.idle_ticks);
        $display("%0d rectangles checked, %0d visible, %0d clipped away, %0d mismatches.",
                 sb.rects_seen, sb.rects_visible, sb.rects_seen - sb.rects_visible,
                 sb.failures);
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/tlr_pkg.sv
hdl/tlr_fifo.sv
hdl/tlr_front.sv
hdl/tlr_back.sv
hdl/tlr_clip.sv
hdl/thick_line_rasterizer_unit.sv
tb/tb_thick_line_rasterizer_unit.sv
